>>> src/rfu_pkg.sv
// ----------------------------------------------------------------------------
// rfu_pkg
// Shared types and constants of the H.264 RTP FU-A packetizer.
// ----------------------------------------------------------------------------
package rfu_pkg;

   localparam int unsigned DEFAULT_MAX_NAL_BYTES = 524288;

   localparam int unsigned NAL_BYTE_W   = 8;
   localparam int unsigned NAL_LENGTH_W = 20;
   localparam int unsigned LIMIT_W      = 11;
   localparam int unsigned TICK_W       = 17;
   localparam int unsigned SEQ_W        = 16;
   localparam int unsigned TIME_W       = 32;

   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = TICK_W;

   localparam logic [CSR_INDEX_W-1:0] REG_FRAGMENT_LIMIT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_TICK_STEP      = 1'b1;

   localparam logic [LIMIT_W-1:0] FRAGMENT_LIMIT_RESET = 11'd1400;
   localparam logic [TICK_W-1:0]  TICK_STEP_RESET      = 17'(90000 / 25);
   localparam logic [LIMIT_W-1:0] MIN_LIMIT            = 11'd2;

   localparam logic [7:0] NRI_MASK  = 8'h60;
   localparam logic [7:0] TYPE_MASK = 8'h1F;
   localparam logic [7:0] FU_A_TYPE = 8'd28;
   localparam logic [7:0] FU_START  = 8'h80;
   localparam logic [7:0] FU_END    = 8'h40;
   localparam logic [4:0] NAL_SPS   = 5'd7;
   localparam logic [4:0] NAL_PPS   = 5'd8;

   localparam int unsigned QUEUE_DEPTH = 4;

   // one request worth of work for the back end
   typedef struct packed {
      logic [NAL_BYTE_W-1:0] data_byte;
      logic [7:0]            fu_ind;
      logic [7:0]            fu_hdr;
      logic                  is_frag_start;
      logic                  first;
      logic                  last;
      logic [SEQ_W-1:0]      seq;
      logic [TIME_W-1:0]     stamp;
   } rfu_cmd_type;

   typedef enum logic [1:0] {
      PH_IND,
      PH_HDR,
      PH_DATA
   } rfu_phase_type;

endpackage

>>> src/rfu_if.sv
// ----------------------------------------------------------------------------
// rfu_if
// Valid/ready channels for NAL bytes in and RTP payload bytes out.
// ----------------------------------------------------------------------------
interface rfu_req_if import rfu_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [NAL_BYTE_W-1:0]   nal_byte;
   logic [NAL_LENGTH_W-1:0] nal_length;

   modport source (output valid, output nal_byte, output nal_length, input ready);
   modport sink   (input valid, input nal_byte, input nal_length, output ready);
endinterface

interface rfu_rsp_if import rfu_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [NAL_BYTE_W-1:0] out_byte;
   logic                  packet_first;
   logic                  packet_last;
   logic [SEQ_W-1:0]      seq_number;
   logic [TIME_W-1:0]     rtp_timestamp;

   modport source (output valid, output out_byte, output packet_first,
                   output packet_last, output seq_number, output rtp_timestamp,
                   input ready);
   modport sink   (input valid, input out_byte, input packet_first,
                   input packet_last, input seq_number, input rtp_timestamp,
                   output ready);
endinterface

>>> src/rfu_front.sv
// ----------------------------------------------------------------------------
// rfu_front
// Accepts NAL bytes, tracks unit position, sequence and timestamp, and
// issues one command per byte that produces payload.
// ----------------------------------------------------------------------------
module rfu_front import rfu_pkg::*; #(
   parameter int unsigned MAX_NAL_BYTES = DEFAULT_MAX_NAL_BYTES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   rfu_req_if.sink                req_bus,
   output logic                   cmd_valid,
   output rfu_cmd_type            cmd,
   input  logic                   cmd_ready
);

   localparam int unsigned LW = $clog2(MAX_NAL_BYTES + 1);
   localparam int unsigned WW = (LW > NAL_LENGTH_W) ? LW : NAL_LENGTH_W;
   localparam int unsigned CW = (LW > LIMIT_W) ? LW : LIMIT_W;

   logic [LIMIT_W-1:0] fragment_limit_ff;
   logic [TICK_W-1:0]  tick_step_ff;
   logic [SEQ_W-1:0]   seq_ff, seq_in;
   logic [TIME_W-1:0]  time_ff, time_in;
   logic [LW-1:0]      pos_ff, pos_in;
   logic [LW-1:0]      len_ff, len_in;
   logic [7:0]         header_ff, header_in;
   logic [LIMIT_W-1:0] fill_ff, fill_in;
   logic               frag_mode_ff, frag_mode_in;

   logic               accept;
   logic [LIMIT_W-1:0] lim;
   logic [WW-1:0]      len_ext;
   logic [LW-1:0]      new_len;
   logic               new_frag;
   logic [LW:0]        pos_inc;
   logic [LW-1:0]      rem;
   logic [LIMIT_W-1:0] size;
   logic [LIMIT_W-1:0] fill_cur;
   logic [LIMIT_W-1:0] fill_dec;
   logic [7:0]         fu_hdr;
   logic [TIME_W-1:0]  time_adv;

   assign req_bus.ready = cmd_ready;
   assign accept        = req_bus.valid && cmd_ready;

   always_comb begin
      lim = (fragment_limit_ff < MIN_LIMIT) ? MIN_LIMIT : fragment_limit_ff;

      // saturate the length, treat zero as one byte
      len_ext = WW'(req_bus.nal_length);
      if (len_ext > WW'(MAX_NAL_BYTES)) begin
         len_ext = WW'(MAX_NAL_BYTES);
      end
      if (len_ext == '0) begin
         len_ext = WW'(1);
      end
      new_len  = LW'(len_ext);
      new_frag = CW'(new_len) > CW'(lim);

      pos_inc = {1'b0, pos_ff} + (LW+1)'(1);
      rem     = (len_ff > pos_ff) ? (len_ff - pos_ff) : LW'(1);

      // first fragment of a unit just over the limit drops one byte
      if (pos_ff == LW'(1) && CW'(rem) <= CW'(lim)) begin
         size = (rem > LW'(1)) ? LIMIT_W'(rem - LW'(1)) : LIMIT_W'(1);
      end else begin
         size = (CW'(rem) < CW'(lim)) ? LIMIT_W'(rem) : lim;
      end

      fu_hdr = header_ff & TYPE_MASK;
      if (pos_ff == LW'(1)) begin
         fu_hdr = fu_hdr | FU_START;
      end else if (CW'(size) >= CW'(rem)) begin
         fu_hdr = fu_hdr | FU_END;
      end

      fill_cur = (fill_ff == '0) ? size : fill_ff;
      fill_dec = fill_cur - LIMIT_W'(1);
      time_adv = time_ff + TIME_W'(tick_step_ff);
   end

   always_comb begin
      seq_in       = seq_ff;
      time_in      = time_ff;
      pos_in       = pos_ff;
      len_in       = len_ff;
      header_in    = header_ff;
      fill_in      = fill_ff;
      frag_mode_in = frag_mode_ff;

      cmd_valid         = 1'b0;
      cmd.data_byte     = req_bus.nal_byte;
      cmd.fu_ind        = (header_ff & NRI_MASK) | FU_A_TYPE;
      cmd.fu_hdr        = fu_hdr;
      cmd.is_frag_start = 1'b0;
      cmd.first         = 1'b0;
      cmd.last          = 1'b0;
      cmd.seq           = seq_ff;
      cmd.stamp         = time_ff;

      if (accept) begin
         if (pos_ff == '0) begin
            len_in       = new_len;
            header_in    = req_bus.nal_byte;
            fill_in      = '0;
            frag_mode_in = new_frag;
            if (new_frag) begin
               pos_in = LW'(1);
            end else begin
               cmd_valid = 1'b1;
               cmd.first = 1'b1;
               cmd.last  = (new_len == LW'(1));
               if (new_len == LW'(1)) begin
                  seq_in = seq_ff + SEQ_W'(1);
                  pos_in = '0;
                  if ((req_bus.nal_byte[4:0] != NAL_SPS) &&
                      (req_bus.nal_byte[4:0] != NAL_PPS)) begin
                     time_in = time_adv;
                  end
               end else begin
                  pos_in = LW'(1);
               end
            end
         end else if (!frag_mode_ff) begin
            cmd_valid = 1'b1;
            cmd.last  = (pos_inc >= {1'b0, len_ff});
            if (pos_inc >= {1'b0, len_ff}) begin
               seq_in  = seq_ff + SEQ_W'(1);
               pos_in  = '0;
               fill_in = '0;
               if ((header_ff[4:0] != NAL_SPS) && (header_ff[4:0] != NAL_PPS)) begin
                  time_in = time_adv;
               end
            end else begin
               pos_in = LW'(pos_inc);
            end
         end else begin
            cmd_valid         = 1'b1;
            cmd.is_frag_start = (fill_ff == '0);
            cmd.last          = (fill_dec == '0);
            fill_in           = fill_dec;
            if (fill_dec == '0) begin
               seq_in = seq_ff + SEQ_W'(1);
            end
            if (pos_inc >= {1'b0, len_ff}) begin
               pos_in  = '0;
               fill_in = '0;
               time_in = time_adv;
            end else begin
               pos_in = LW'(pos_inc);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fragment_limit_ff <= FRAGMENT_LIMIT_RESET;
         tick_step_ff      <= TICK_STEP_RESET;
         seq_ff            <= '0;
         time_ff           <= '0;
         pos_ff            <= '0;
         fill_ff           <= '0;
         frag_mode_ff      <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_FRAGMENT_LIMIT: fragment_limit_ff <= csr_data[LIMIT_W-1:0];
               REG_TICK_STEP:      tick_step_ff      <= csr_data[TICK_W-1:0];
               default: ;
            endcase
         end
         seq_ff       <= seq_in;
         time_ff      <= time_in;
         pos_ff       <= pos_in;
         fill_ff      <= fill_in;
         frag_mode_ff <= frag_mode_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff    <= len_in;
      header_ff <= header_in;
   end

endmodule

>>> src/rfu_queue.sv
// ----------------------------------------------------------------------------
// rfu_queue
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module rfu_queue import rfu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   input  rfu_cmd_type push_cmd,
   output logic        push_ready,
   output logic        pop_valid,
   output rfu_cmd_type pop_cmd,
   input  logic        pop_ready
);

   localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

   rfu_cmd_type     entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign push_ready = (count_ff != NW'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + NW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> src/rfu_back.sv
// ----------------------------------------------------------------------------
// rfu_back
// Expands queued commands into payload bytes: a plain byte, or FU indicator,
// FU header and data byte for the start of a fragment.
// ----------------------------------------------------------------------------
module rfu_back import rfu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  rfu_cmd_type cmd,
   output logic        cmd_ready,
   rfu_rsp_if.source   rsp_bus
);

   rfu_phase_type         phase_ff, phase_in;
   logic                  valid_ff;
   logic [NAL_BYTE_W-1:0] byte_ff, byte_in;
   logic                  first_ff, first_in;
   logic                  last_ff, last_in;
   logic [SEQ_W-1:0]      seq_ff;
   logic [TIME_W-1:0]     stamp_ff;
   logic                  load;

   // output register is free when empty or being taken
   assign load = !valid_ff || rsp_bus.ready;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (load && cmd_valid) begin
         case (phase_ff)
            PH_IND:  phase_in = cmd.is_frag_start ? PH_HDR : PH_IND;
            PH_HDR:  phase_in = PH_DATA;
            PH_DATA: phase_in = PH_IND;
            default: phase_in = PH_IND;
         endcase
      end
   end

   // byte selection and pop
   always_comb begin
      byte_in   = cmd.data_byte;
      first_in  = cmd.first;
      last_in   = cmd.last;
      cmd_ready = 1'b0;
      case (phase_ff)
         PH_IND: begin
            if (cmd.is_frag_start) begin
               byte_in  = cmd.fu_ind;
               first_in = 1'b1;
               last_in  = 1'b0;
            end else begin
               cmd_ready = load;
            end
         end
         PH_HDR: begin
            byte_in  = cmd.fu_hdr;
            first_in = 1'b0;
            last_in  = 1'b0;
         end
         PH_DATA: begin
            cmd_ready = load;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IND;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (load) begin
            valid_ff <= cmd_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load && cmd_valid) begin
         byte_ff  <= byte_in;
         first_ff <= first_in;
         last_ff  <= last_in;
         seq_ff   <= cmd.seq;
         stamp_ff <= cmd.stamp;
      end
   end

   assign rsp_bus.valid         = valid_ff;
   assign rsp_bus.out_byte      = byte_ff;
   assign rsp_bus.packet_first  = first_ff;
   assign rsp_bus.packet_last   = last_ff;
   assign rsp_bus.seq_number    = seq_ff;
   assign rsp_bus.rtp_timestamp = stamp_ff;

endmodule

>>> src/h264_rtp_fu_a_packetizer.sv
// ----------------------------------------------------------------------------
// h264_rtp_fu_a_packetizer
// Packs H.264 NAL units into RTP payloads, single packet or FU-A fragments.
// ----------------------------------------------------------------------------
//   channel   direction  handshake      payload
//   req_bus   in         valid/ready    nal_byte, nal_length (on header byte)
//   rsp_bus   out        valid/ready    out_byte, packet_first, packet_last,
//                                       seq_number, rtp_timestamp
//   csr_*     in         write enable   csr_index, csr_data
//
// A NAL byte is taken every cycle while the command queue has room. Each
// byte gives one payload byte, except the header byte of a fragmented unit
// (none) and the first data byte of a fragment (FU indicator, FU header and
// data, three payload bytes), so each fragment adds two bytes of FU framing.
// A payload byte passes through the command queue and the output register
// of the back end; output stalls back up through the queue.
// ----------------------------------------------------------------------------
module h264_rtp_fu_a_packetizer import rfu_pkg::*; #(
   parameter int unsigned MAX_NAL_BYTES = DEFAULT_MAX_NAL_BYTES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   rfu_req_if.sink                req_bus,
   rfu_rsp_if.source              rsp_bus
);

   logic        front_valid, front_ready;
   rfu_cmd_type front_cmd;
   logic        back_valid, back_ready;
   rfu_cmd_type back_cmd;

   rfu_front #(
      .MAX_NAL_BYTES(MAX_NAL_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_bus   (req_bus),
      .cmd_valid (front_valid),
      .cmd       (front_cmd),
      .cmd_ready (front_ready)
   );

   rfu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_cmd   (front_cmd),
      .push_ready (front_ready),
      .pop_valid  (back_valid),
      .pop_cmd    (back_cmd),
      .pop_ready  (back_ready)
   );

   rfu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (back_valid),
      .cmd       (back_cmd),
      .cmd_ready (back_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule
